/* hw/rtl/linear_sieve_moebius_mertens_defines.svh */
// Assertion macros for the Moebius sieve block
`ifndef LINEAR_SIEVE_MOEBIUS_MERTENS_DEFINES_SVH
`define LINEAR_SIEVE_MOEBIUS_MERTENS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst
`define LSMM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsmm assertion failed");

// Next-cycle implication, sampled on clk, off during rst
`define LSMM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsmm assertion failed");

`endif

/* hw/rtl/lsmm_pkg.sv */
// Shared types and constants for the Moebius sieve block
package lsmm_pkg;

  // Field widths fixed by the interface
  localparam int NUM_W  = 22;
  localparam int MU_W   = 2;
  localparam int MERT_W = 30;

  // Largest value the 22-bit limit register can hold
  localparam int LIMIT_CAP = 4194303;
  localparam logic [NUM_W-1:0] LIMIT_RESET = 22'd2097152;

  // Mertens sum modulus
  localparam logic [MERT_W-1:0] MERT_MOD = 30'd1000000007;

  // Store word: {composite mark, moebius[1:0]}
  localparam int STORE_W = 3;

  localparam logic signed [MU_W-1:0] MU_POS  = 2'sd1;
  localparam logic signed [MU_W-1:0] MU_NEG  = -2'sd1;
  localparam logic signed [MU_W-1:0] MU_ZERO = 2'sd0;

  // Controller states
  typedef enum logic [3:0] {
    ST_BOOT_CLR,
    ST_IDLE,
    ST_RST_CLR,
    ST_CHECK,
    ST_CLASSIFY,
    ST_WALK_RD,
    ST_WALK_MUL,
    ST_WALK_CMP,
    ST_WALK_DIV,
    ST_WALK_WR,
    ST_FINISH
  } lsmm_state_t;

  // Controller to datapath
  typedef struct packed {
    logic restart_init;
    logic clr_step;
    logic classify;
    logic mul;
    logic div_start;
    logic store_wr;
    logic j_inc;
    logic finish;
  } lsmm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic exh;
    logic j_lt_count;
    logic prod_gt_lim;
    logic div_busy;
    logic rem_zero;
    logic out_free;
  } lsmm_sts_t;

endpackage

/* hw/rtl/lsmm_ifs.sv */
// Channel interfaces: request, result and configuration write

interface lsmm_req_if import lsmm_pkg::*; ();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface lsmm_rsp_if import lsmm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [NUM_W-1:0]         number;
  logic signed [MU_W-1:0]   moebius;
  logic [MERT_W-1:0]        mertens_mod;
  logic                     is_prime;
  logic                     exhausted;

  modport source (output valid, output number, output moebius, output mertens_mod,
                  output is_prime, output exhausted, input ready);
  modport sink   (input valid, input number, input moebius, input mertens_mod,
                  input is_prime, input exhausted, output ready);
endinterface

interface lsmm_cfg_if import lsmm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] sieve_limit;

  modport source (output valid, output sieve_limit, input ready);
  modport sink   (input valid, input sieve_limit, output ready);
endinterface

/* hw/rtl/lsmm_ram.sv */
// Generic single-write, single-read RAM with registered read data
module lsmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/lsmm_div.sv */
// Bit-serial restoring remainder unit, one dividend bit per cycle
module lsmm_div #(
  parameter int W = 22
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic         rem_zero
);

  localparam int CNTW = $clog2(W + 1);

  logic [CNTW-1:0] cnt;
  logic [W-1:0]    rem;
  logic [W-1:0]    shreg;
  logic [W:0]      trial;
  logic [W:0]      diff;

  // Shift in the next dividend bit, subtract when it fits
  assign trial = {rem, shreg[W-1]};
  assign diff  = trial - {1'b0, divisor};

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Partial remainder and dividend shifter
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= dividend;
    end else if (busy) begin
      shreg <= {shreg[W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= diff[W-1:0];
      end else begin
        rem <= trial[W-1:0];
      end
    end
  end

  assign rem_zero = (rem == '0);

endmodule

/* hw/rtl/lsmm_ctrl.sv */
// Sequencer for clearing, classification and the prime walk
module lsmm_ctrl import lsmm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_restart,
  output logic      req_ready,
  input  lsmm_sts_t sts,
  output lsmm_cmd_t cmd
);

  lsmm_state_t state;
  lsmm_state_t state_next;

  // State register; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_BOOT_CLR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_BOOT_CLR: begin
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = req_restart ? ST_RST_CLR : ST_CHECK;
      end
      ST_RST_CLR: begin
        if (sts.clr_last) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = sts.exh ? ST_FINISH : ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        state_next = ST_WALK_RD;
      end
      ST_WALK_RD: begin
        state_next = sts.j_lt_count ? ST_WALK_MUL : ST_FINISH;
      end
      ST_WALK_MUL: begin
        state_next = ST_WALK_CMP;
      end
      ST_WALK_CMP: begin
        state_next = sts.prod_gt_lim ? ST_FINISH : ST_WALK_DIV;
      end
      ST_WALK_DIV: begin
        if (!sts.div_busy) state_next = ST_WALK_WR;
      end
      ST_WALK_WR: begin
        state_next = sts.rem_zero ? ST_FINISH : ST_WALK_RD;
      end
      ST_FINISH: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      ST_BOOT_CLR, ST_RST_CLR: begin
        cmd.clr_step = 1'b1;
      end
      ST_IDLE: begin
        req_ready        = 1'b1;
        cmd.restart_init = req_valid & req_restart;
      end
      ST_CLASSIFY: begin
        cmd.classify = 1'b1;
      end
      ST_WALK_MUL: begin
        cmd.mul = 1'b1;
      end
      ST_WALK_CMP: begin
        cmd.div_start = !sts.prod_gt_lim;
      end
      ST_WALK_WR: begin
        cmd.store_wr = 1'b1;
        cmd.j_inc    = !sts.rem_zero;
      end
      ST_FINISH: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* hw/rtl/lsmm_dp.sv */
// Sieve datapath: stores, prime list, product, remainder unit, result register
module lsmm_dp import lsmm_pkg::*; #(
  parameter int MAX_NUMBER  = 2097152,
  parameter int PRIME_SLOTS = 262144
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [NUM_W-1:0]       cfg_data,
  input  lsmm_cmd_t              cmd,
  output lsmm_sts_t              sts,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [NUM_W-1:0]       out_number,
  output logic signed [MU_W-1:0] out_moebius,
  output logic [MERT_W-1:0]      out_mertens,
  output logic                   out_prime,
  output logic                   out_exh
);

  localparam int MAX_EFF = (MAX_NUMBER > LIMIT_CAP) ? LIMIT_CAP : MAX_NUMBER;
  localparam int SDEPTH  = MAX_EFF + 1;
  localparam int SAW     = $clog2(SDEPTH);
  localparam int NW      = $clog2(MAX_EFF + 2);
  localparam int PW      = SAW;
  localparam int PAW     = $clog2(PRIME_SLOTS);
  localparam int CW      = $clog2(PRIME_SLOTS + 1);
  localparam logic [CW-1:0]  SLOTS_C = CW'(PRIME_SLOTS);
  localparam logic [SAW-1:0] LAST_A  = SAW'(MAX_EFF);

  logic [NUM_W-1:0]       sieve_limit;
  logic [NW-1:0]          next_num;
  logic [MERT_W-1:0]      mertens;
  logic [MERT_W-1:0]      mert_next;
  logic [CW-1:0]          prime_cnt;
  logic [CW-1:0]          walk_idx;
  logic [SAW-1:0]         clr_addr;
  logic signed [MU_W-1:0] mu_cur;
  logic                   prime_cur;
  logic [PW-1:0]          prime_p;
  logic [2*NW-1:0]        prod;
  logic [2*NW-1:0]        prod_next;

  logic [31:0]            lim_wide;
  logic [NW-1:0]          lim;
  logic                   exh;

  logic                   st_we;
  logic [SAW-1:0]         st_waddr;
  logic [STORE_W-1:0]     st_wdata;
  logic [STORE_W-1:0]     st_rdata;
  logic signed [MU_W-1:0] mu_wr;

  logic                   pl_we;
  logic [PW-1:0]          pl_rdata;

  logic                   n_is_one;
  logic                   cls_prime;
  logic signed [MU_W-1:0] cls_mu;

  logic                   div_busy;
  logic                   rem_zero;

  // Effective limit: register clamped to the last store address
  always_comb begin
    lim_wide = 32'(sieve_limit);
    if (lim_wide > 32'(MAX_EFF)) begin
      lim_wide = 32'(MAX_EFF);
    end
  end
  assign lim = lim_wide[NW-1:0];
  assign exh = (next_num > lim);

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      sieve_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      sieve_limit <= cfg_data;
    end
  end

  // Mark/moebius store: clearing pass or walk write, read at the current number
  assign mu_wr    = rem_zero ? MU_ZERO : -mu_cur;
  assign st_we    = cmd.clr_step | cmd.store_wr;
  assign st_waddr = cmd.clr_step ? clr_addr : prod[SAW-1:0];
  assign st_wdata = cmd.clr_step ? '0 : {1'b1, mu_wr};

  lsmm_ram #(
    .WIDTH (STORE_W),
    .DEPTH (SDEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (next_num[SAW-1:0]),
    .rdata (st_rdata)
  );

  // Classification of the current number
  assign n_is_one  = (next_num == NW'(1));
  assign cls_prime = !n_is_one && !st_rdata[STORE_W-1];
  always_comb begin
    if (n_is_one) begin
      cls_mu = MU_POS;
    end else if (!st_rdata[STORE_W-1]) begin
      cls_mu = MU_NEG;
    end else begin
      cls_mu = signed'(st_rdata[MU_W-1:0]);
    end
  end

  // Prime list: append on a new prime while slots remain
  assign pl_we = cmd.classify & cls_prime & (prime_cnt < SLOTS_C);

  lsmm_ram #(
    .WIDTH (PW),
    .DEPTH (PRIME_SLOTS)
  ) u_primes (
    .clk   (clk),
    .we    (pl_we),
    .waddr (prime_cnt[PAW-1:0]),
    .wdata (next_num[PW-1:0]),
    .raddr (walk_idx[PAW-1:0]),
    .rdata (pl_rdata)
  );

  // Product of the current number and the walked prime
  assign prod_next = (2*NW)'(next_num) * (2*NW)'(pl_rdata);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod    <= prod_next;
      prime_p <= pl_rdata;
    end
    if (cmd.classify) begin
      mu_cur    <= cls_mu;
      prime_cur <= cls_prime;
    end
  end

  // Divisibility test of the current number by the walked prime
  lsmm_div #(
    .W (NW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (next_num),
    .divisor  (NW'(prime_p)),
    .busy     (div_busy),
    .rem_zero (rem_zero)
  );

  // Running Mertens sum update
  always_comb begin
    if (mu_cur == MU_POS) begin
      mert_next = (mertens == MERT_MOD - 30'd1) ? '0 : mertens + 30'd1;
    end else if (mu_cur == MU_NEG) begin
      mert_next = (mertens == '0) ? MERT_MOD - 30'd1 : mertens - 30'd1;
    end else begin
      mert_next = mertens;
    end
  end

  // Sieve state: clear address, counts, number, sum
  always_ff @(posedge clk) begin
    if (rst) begin
      next_num  <= NW'(1);
      mertens   <= '0;
      prime_cnt <= '0;
      walk_idx  <= '0;
      clr_addr  <= '0;
    end else begin
      if (cmd.restart_init) begin
        next_num  <= NW'(1);
        mertens   <= '0;
        prime_cnt <= '0;
        clr_addr  <= '0;
      end
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.classify) begin
        walk_idx <= '0;
        if (pl_we) begin
          prime_cnt <= prime_cnt + 1'b1;
        end
      end
      if (cmd.j_inc) begin
        walk_idx <= walk_idx + 1'b1;
      end
      if (cmd.finish && !exh) begin
        next_num <= next_num + 1'b1;
        mertens  <= mert_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (exh) begin
        out_number  <= '0;
        out_moebius <= MU_ZERO;
        out_mertens <= mertens;
        out_prime   <= 1'b0;
        out_exh     <= 1'b1;
      end else begin
        out_number  <= NUM_W'(next_num);
        out_moebius <= mu_cur;
        out_mertens <= mert_next;
        out_prime   <= prime_cur;
        out_exh     <= 1'b0;
      end
    end
  end

  // Status to the controller
  always_comb begin
    sts.clr_last    = (clr_addr == LAST_A);
    sts.exh         = exh;
    sts.j_lt_count  = (walk_idx < prime_cnt);
    sts.prod_gt_lim = (prod > (2*NW)'(lim));
    sts.div_busy    = div_busy;
    sts.rem_zero    = rem_zero;
    sts.out_free    = !out_valid || out_ready;
  end

endmodule

/* hw/rtl/linear_sieve_moebius_mertens.sv */
// Flow: an exhausted item goes from the limit check straight to the result register; others
// are classified, then walk the prime list (read, multiply, bound compare, remainder test,
// store write per prime) until the product passes the limit, the prime divides the number or
// the list ends. W = clog2(min(MAX_NUMBER,4194303)+2) (22 by default) is the width of the
// bit-serial remainder unit; one item at a time. Reset (and a restart item) runs a clearing
// pass over min(MAX_NUMBER,4194303)+1 entries with req.ready low; cfg taken every cycle.
`include "linear_sieve_moebius_mertens_defines.svh"

module linear_sieve_moebius_mertens import lsmm_pkg::*; #(
  parameter int MAX_NUMBER  = 2097152,
  parameter int PRIME_SLOTS = 262144
) (
  input logic        clk,
  input logic        rst,
  lsmm_req_if.sink   req,
  lsmm_rsp_if.source rsp,
  lsmm_cfg_if.sink   cfg
);

  lsmm_cmd_t ctl_cmd;
  lsmm_sts_t ctl_sts;
  logic      exh_blank;

  // Limit register takes a transfer every cycle
  assign cfg.ready = 1'b1;

  lsmm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_restart (req.restart),
    .req_ready   (req.ready),
    .sts         (ctl_sts),
    .cmd         (ctl_cmd)
  );

  lsmm_dp #(
    .MAX_NUMBER  (MAX_NUMBER),
    .PRIME_SLOTS (PRIME_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg.valid),
    .cfg_data    (cfg.sieve_limit),
    .cmd         (ctl_cmd),
    .sts         (ctl_sts),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .out_number  (rsp.number),
    .out_moebius (rsp.moebius),
    .out_mertens (rsp.mertens_mod),
    .out_prime   (rsp.is_prime),
    .out_exh     (rsp.exhausted)
  );

  // Fields an exhausted result leaves blank
  assign exh_blank = (rsp.number == '0) && (rsp.moebius == MU_ZERO) && !rsp.is_prime;

  // Checks
  `LSMM_ASSERT_IMP(a_exh_blank, rsp.valid && rsp.exhausted, exh_blank)
  `LSMM_ASSERT_IMP(a_prime_mu, rsp.valid && rsp.is_prime, rsp.moebius == MU_NEG && !rsp.exhausted)
  `LSMM_ASSERT_IMP(a_mert_range, rsp.valid, rsp.mertens_mod < MERT_MOD)
  `LSMM_ASSERT_NXT(a_one_at_a_time, req.valid && req.ready, !req.ready)

endmodule

/* dv/linear_sieve_moebius_mertens_checker.sv */
// Scoreboard for the Moebius sieve: watches all three channels, predicts each result, compares
`timescale 1ns / 100ps

module linear_sieve_moebius_mertens_checker import lsmm_pkg::*; #(
  parameter int MAX_NUMBER  = 2097152,
  parameter int PRIME_SLOTS = 262144
) (
  input  logic clk,
  input  logic rst,
  lsmm_req_if  req,
  lsmm_rsp_if  rsp,
  lsmm_cfg_if  cfg,
  output int   fails,
  output int   pending,
  output int   checked
);

  typedef struct packed {
    logic [NUM_W-1:0]       number;
    logic signed [MU_W-1:0] moebius;
    logic [MERT_W-1:0]      mertens_mod;
    logic                   is_prime;
    logic                   exhausted;
  } sieve_result_t;

  // Shadow copy of the sieve state
  bit                     composite [0:MAX_NUMBER];
  logic signed [MU_W-1:0] mu_ahead  [0:MAX_NUMBER];
  logic [NUM_W-2:0]       prime_tab [0:PRIME_SLOTS-1];
  int unsigned            prime_total;
  logic [MERT_W-1:0]      mertens_acc;
  logic [NUM_W-1:0]       next_n;
  logic [NUM_W-1:0]       limit_reg;

  sieve_result_t awaited_results [$];
  int mismatch_count = 0;
  int result_count = 0;

  function automatic void clear_sieve();
    for (int k = 0; k <= MAX_NUMBER; k++) begin
      composite[k] = 1'b0;
      mu_ahead[k] = MU_ZERO;
    end
    prime_total = 0;
    mertens_acc = '0;
    next_n = NUM_W'(1);
  endfunction

  // One sieve step: classify the next number, walk the primes ahead, update the Mertens sum
  function automatic sieve_result_t sieve_next(input logic restart);
    sieve_result_t r;
    longint unsigned lim, n, p, prod;
    logic signed [MU_W-1:0] mu;
    logic prime;
    if (restart) clear_sieve();
    lim = (limit_reg > MAX_NUMBER) ? MAX_NUMBER : limit_reg;
    n = next_n;
    r = '0;
    prime = 1'b0;
    // past the limit nothing moves; the held sum is reported
    if (n == 0 || n > lim) begin
      r.mertens_mod = mertens_acc;
      r.exhausted = 1'b1;
      return r;
    end
    if (n == 1) begin
      mu = MU_POS;
    end else if (!composite[n]) begin
      mu = MU_NEG;
      prime = 1'b1;
      // prime list saturates; the prime is still reported
      if (prime_total < PRIME_SLOTS) begin
        prime_tab[prime_total] = n[NUM_W-2:0];
        prime_total++;
      end
    end else begin
      mu = mu_ahead[n];
    end
    for (int unsigned j = 0; j < prime_total; j++) begin
      p = prime_tab[j];
      prod = n * p;
      if (p == 0 || prod > lim) break;
      composite[prod] = 1'b1;
      if (n % p != 0) begin
        mu_ahead[prod] = -mu;
      end else begin
        mu_ahead[prod] = MU_ZERO;
        break;
      end
    end
    if (mu == MU_POS)
      mertens_acc = (mertens_acc == MERT_MOD - 30'd1) ? '0 : mertens_acc + 1'b1;
    else if (mu == MU_NEG)
      mertens_acc = (mertens_acc == '0) ? MERT_MOD - 30'd1 : mertens_acc - 1'b1;
    next_n = NUM_W'(n + 1);
    r.number = n[NUM_W-1:0];
    r.moebius = mu;
    r.mertens_mod = mertens_acc;
    r.is_prime = prime;
    r.exhausted = 1'b0;
    return r;
  endfunction

  // Results first (they belong to older requests), then new requests, then register writes
  always @(posedge clk) begin : watch
    sieve_result_t want, got;
    if (rst) begin
      limit_reg = LIMIT_RESET;
      clear_sieve();
      awaited_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.number = rsp.number;
        got.moebius = rsp.moebius;
        got.mertens_mod = rsp.mertens_mod;
        got.is_prime = rsp.is_prime;
        got.exhausted = rsp.exhausted;
        result_count++;
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d with no request pending: number %0d moebius %0d mertens %0d",
                     result_count, got.number, got.moebius, got.mertens_mod);
        end else begin
          want = awaited_results.pop_front();
          if (want.number !== got.number || want.moebius !== got.moebius ||
              want.mertens_mod !== got.mertens_mod || want.is_prime !== got.is_prime ||
              want.exhausted !== got.exhausted) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"result %0d mismatch (exp/got): number %0d/%0d moebius %0d/%0d ",
                        "mertens %0d/%0d prime %0b/%0b exhausted %0b/%0b"},
                       result_count, want.number, got.number, want.moebius, got.moebius,
                       want.mertens_mod, got.mertens_mod, want.is_prime, got.is_prime,
                       want.exhausted, got.exhausted);
          end
        end
      end
      if (req.valid && req.ready)
        awaited_results.push_back(sieve_next(req.restart));
      if (cfg.valid && cfg.ready)
        limit_reg = cfg.sieve_limit;
    end
    pending <= awaited_results.size();
    fails <= mismatch_count;
    checked <= result_count;
  end

endmodule

/* dv/linear_sieve_moebius_mertens_test.sv */
// Top of the Moebius sieve bench: clock, reset, request and limit stimulus, verdict
`timescale 1ns / 100ps

module linear_sieve_moebius_mertens_test;
  import lsmm_pkg::*;

  // Small sieve so the clearing pass stays short; few prime slots so the list fills
  localparam int SIEVE_MAX    = 4096;
  localparam int PRIME_CAP    = 32;
  localparam int RANDOM_ITEMS = 2000;
  localparam int TAIL_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 4000000;

  logic clk;
  logic rst;

  lsmm_req_if req_ch ();
  lsmm_rsp_if rsp_ch ();
  lsmm_cfg_if cfg_ch ();

  int fails;
  int pending;
  int checked;

  int sent = 0;
  int restarts = 0;
  int settings = 0;
  int burst_left = 0;
  int unsigned cycle_count = 0;
  int stall_mode = 0;
  int stall_left = 0;

  linear_sieve_moebius_mertens #(
    .MAX_NUMBER (SIEVE_MAX),
    .PRIME_SLOTS(PRIME_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  linear_sieve_moebius_mertens_checker #(
    .MAX_NUMBER (SIEVE_MAX),
    .PRIME_SLOTS(PRIME_CAP)
  ) checker_i (
    .clk    (clk),
    .rst    (rst),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .cfg    (cfg_ch),
    .fails  (fails),
    .pending(pending),
    .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("linear_sieve_moebius_mertens_test: done, errors");
      $finish;
    end
  end

  // Result side back-pressure: switches between stall patterns
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(30, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: rsp_ch.ready <= 1'b1;
      1: rsp_ch.ready <= 1'($urandom_range(0, 1));
      2: rsp_ch.ready <= ($urandom_range(0, 5) == 0);
      default: rsp_ch.ready <= cycle_count[2];
    endcase
  end

  // One request transfer; bursts of random length separated by random gaps
  task automatic send_item(input logic restart_bit);
    int gap;
    req_ch.valid <= 1'b1;
    req_ch.restart <= restart_bit;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
    if (restart_bit) restarts++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off requests until every outstanding result has come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_limit(input logic [NUM_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.sieve_limit <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    settings++;
  endtask

  initial begin : stimulus
    logic [NUM_W-1:0] limit;
    int phase_len;
    int pick;
    int directed_done;
    req_ch.valid = 1'b0;
    req_ch.restart = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.sieve_limit = '0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset limit sits above the sieve size: 1, primes, a square, mu of 6, sum wrapping below 0
    repeat (6) send_item(1'b0);
    drain();
    // Limit of zero: every item exhausted, restart included
    write_limit('0);
    send_item(1'b0);
    send_item(1'b1);
    drain();
    // Limit of one: only number one, then exhausted
    write_limit(NUM_W'(1));
    send_item(1'b1);
    send_item(1'b0);
    drain();
    // Limit of eight: full run to the bound and one past it
    write_limit(NUM_W'(8));
    send_item(1'b1);
    repeat (8) send_item(1'b0);
    drain();
    // Raise to the register maximum without restart: 9..12 read entries never marked
    write_limit(NUM_W'(LIMIT_CAP));
    repeat (4) send_item(1'b0);
    drain();
    directed_done = sent;

    // Random phases, one limit setting each, mostly advancing runs from a fresh restart
    while (sent - directed_done < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: limit = NUM_W'($urandom_range(0, 2));
        1, 2: limit = NUM_W'(SIEVE_MAX);
        3, 4: limit = NUM_W'($urandom_range(SIEVE_MAX + 1, LIMIT_CAP));
        5: limit = NUM_W'($urandom());
        default: limit = NUM_W'($urandom_range(16, SIEVE_MAX));
      endcase
      write_limit(limit);
      phase_len = (limit < 16) ? $urandom_range(3, 12) : $urandom_range(40, 400);
      if ($urandom_range(0, 4) != 0) send_item(1'b1);
      for (int k = 0; k < phase_len; k++)
        send_item($urandom_range(0, 149) == 0);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d requests (%0d restarts) over %0d limit settings, %0d results checked",
             sent, restarts, settings, checked);
    if (fails == 0 && pending == 0)
      $display("linear_sieve_moebius_mertens_test: done, clean");
    else
      $display("linear_sieve_moebius_mertens_test: done, errors");
    $finish;
  end

endmodule
